[design/mma_pkg.sv]
// Shared types and constants for the Montgomery modular ALU.
package mma_pkg;

    localparam int DIV_DEPTH = 64;               // one restoring step per bit of operand_a
    localparam int PIPE_LAT  = DIV_DEPTH + 5;    // accept edge to the edge that takes the result

    typedef enum logic [2:0] {
        ACT_TRANSFORM = 3'd0,
        ACT_REVERT    = 3'd1,
        ACT_ADD       = 3'd2,
        ACT_SUBTRACT  = 3'd3,
        ACT_MULTIPLY  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        CFG_MODULUS       = 2'd0,
        CFG_RADIX_BITS    = 2'd1,
        CFG_NEG_INVERSE   = 2'd2,
        CFG_RADIX_SQUARED = 2'd3
    } t_cfg_idx;

    // operands that ride alongside the division pipeline
    typedef struct packed {
        t_action     action;
        logic [31:0] a;
        logic [31:0] b;
    } t_side;

endpackage

[design/montgomery_modular_alu_core.sv]
// Top level of the Montgomery modular ALU: config registers and REDC pipeline.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | start / busy           | i_action, i_operand_a, i_operand_b
//  result  | o_valid strobe         | o_result
//  config  | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
// One item per cycle while busy is low; each result strobes on o_valid once it has
// passed the 64-stage restoring remainder for a mod n, then the multiply, n' multiply,
// m*n multiply, add/shift and final correction stages.
// Synchronous reset clears the valid bits; busy is high in reset and the
// cycle after. The result side cannot stall, so nothing holds the pipeline.
module montgomery_modular_alu_core #(
    parameter int MOD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [63:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    output logic [31:0] o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [32:0] i_cfg_wdata
);
    import mma_pkg::*;

    localparam int W  = MOD_WIDTH;
    localparam int SW = 2 * W + 2;

    logic [32:0] r_modulus;
    logic [5:0]  r_radix_bits;
    logic [31:0] r_neg_inverse;
    logic [31:0] r_radix_squared;
    logic        r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus       <= 33'd1;
            r_radix_bits    <= 6'd1;
            r_neg_inverse   <= '0;
            r_radix_squared <= '0;
            r_run           <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MODULUS:       r_modulus       <= i_cfg_wdata;
                    CFG_RADIX_BITS:    r_radix_bits    <= i_cfg_wdata[5:0];
                    CFG_NEG_INVERSE:   r_neg_inverse   <= i_cfg_wdata[31:0];
                    CFG_RADIX_SQUARED: r_radix_squared <= i_cfg_wdata[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = ~r_run;

    // effective modulus and radix exponent
    logic [32:0] mod_cap;
    logic [W:0]  n_eff;
    logic [5:0]  k_eff;
    logic [W:0]  rmask_w;
    logic [W-1:0] rmask;

    always_comb begin
        mod_cap = 33'd1 << W;
        if (r_modulus == 33'd0) begin
            n_eff = (W+1)'(1);
        end else if (r_modulus > mod_cap) begin
            n_eff = (W+1)'(mod_cap);
        end else begin
            n_eff = (W+1)'(r_modulus);
        end
        k_eff   = (r_radix_bits > 6'(W)) ? 6'(W) : r_radix_bits;
        rmask_w = ((W+1)'(1) << k_eff) - (W+1)'(1);
        rmask   = rmask_w[W-1:0];
    end

    logic  accept;
    t_side side_in;

    assign accept         = start & ~busy;
    assign side_in.action = t_action'(i_action);
    assign side_in.a      = 32'(i_operand_a[W-1:0]);
    assign side_in.b      = 32'(i_operand_b[W-1:0]);

    logic         d_valid;
    logic [W-1:0] d_rem;
    t_side        d_side;

    mma_div_pipe #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_dividend (i_operand_a),
        .i_modulus  (n_eff),
        .i_side     (side_in),
        .o_valid    (d_valid),
        .o_rem      (d_rem),
        .o_side     (d_side)
    );

    // stage 1: t = operand product, plus add/subtract
    logic [W-1:0]   mul_x, mul_y;
    logic [63:0]    as_sum, as_dif, as_res;
    logic [63:0]    a64, b64, n64;

    always_comb begin
        a64 = 64'(d_side.a[W-1:0]);
        b64 = 64'(d_side.b[W-1:0]);
        n64 = 64'(n_eff);
        as_sum = a64 + b64;
        if (as_sum >= n64) begin
            as_sum = as_sum - n64;
        end
        as_dif = a64 - b64;
        if (b64 > a64) begin
            as_dif = as_dif + n64;
        end
        mul_x = d_side.a[W-1:0];
        mul_y = W'(1);
        as_res = '0;
        case (d_side.action)
            ACT_TRANSFORM: begin
                mul_x = d_rem;
                mul_y = r_radix_squared[W-1:0];
            end
            ACT_MULTIPLY:  mul_y  = d_side.b[W-1:0];
            ACT_ADD:       as_res = as_sum;
            ACT_SUBTRACT:  as_res = as_dif;
            default: ;
        endcase
    end

    logic          r_v1, r_v2, r_v3, r_v4;
    t_action       r_act1, r_act2, r_act3, r_act4;
    logic [31:0]   r_as1, r_as2, r_as3, r_as4;
    logic [2*W-1:0] r_t1, r_t2, r_t3;
    logic [W-1:0]  r_m2;
    logic [2*W:0]  r_p3;
    logic [SW-1:0] r_q4;
    logic          r_out_vld;
    logic [31:0]   r_out_res;

    logic [2*W-1:0] m_prod;
    logic [SW-1:0]  sum_tp;
    logic [SW-1:0]  q_fix;
    logic [SW+31:0] q_ext;
    logic [31:0]    n_res;

    assign m_prod = r_t1[W-1:0] * r_neg_inverse[W-1:0];
    assign sum_tp = SW'(r_t3) + SW'(r_p3);

    always_comb begin
        q_fix = (r_q4 >= SW'(n_eff)) ? (r_q4 - SW'(n_eff)) : r_q4;
        q_ext = (SW+32)'(q_fix);
        case (r_act4)
            ACT_TRANSFORM, ACT_REVERT, ACT_MULTIPLY: n_res = q_ext[31:0];
            ACT_ADD, ACT_SUBTRACT:                   n_res = r_as4;
            default:                                 n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_v1      <= d_valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_out_vld <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act1 <= d_side.action;
        r_as1  <= as_res[31:0];
        r_t1   <= mul_x * mul_y;

        r_act2 <= r_act1;
        r_as2  <= r_as1;
        r_t2   <= r_t1;
        r_m2   <= m_prod[W-1:0] & rmask;

        r_act3 <= r_act2;
        r_as3  <= r_as2;
        r_t3   <= r_t2;
        r_p3   <= r_m2 * n_eff;

        r_act4 <= r_act3;
        r_as4  <= r_as3;
        r_q4   <= sum_tp >> k_eff;

        r_out_res <= n_res;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out_res;

endmodule

[design/mma_div_pipe.sv]
// Pipelined restoring remainder: 64-bit dividend mod a modulus of up to W+1 bits.
module mma_div_pipe #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [63:0]    i_dividend,
    input  logic [W:0]     i_modulus,
    input  mma_pkg::t_side i_side,
    output logic           o_valid,
    output logic [W-1:0]   o_rem,
    output mma_pkg::t_side o_side
);
    import mma_pkg::*;

    logic         r_vld [DIV_DEPTH];
    logic [W-1:0] r_rem [DIV_DEPTH];
    logic [63:0]  r_dvd [DIV_DEPTH];
    t_side        r_side[DIV_DEPTH];

    logic [W-1:0] n_rem [DIV_DEPTH];
    logic [63:0]  n_dvd [DIV_DEPTH];

    always_comb begin
        logic [W-1:0] rin;
        logic [63:0]  din;
        logic [W:0]   shifted;
        for (int i = 0; i < DIV_DEPTH; i++) begin
            if (i == 0) begin
                rin = '0;
                din = i_dividend;
            end else begin
                rin = r_rem[i-1];
                din = r_dvd[i-1];
            end
            shifted = {rin, din[63]};
            // remainder stays below the modulus, so one subtract per bit
            if (shifted >= i_modulus) begin
                n_rem[i] = W'(shifted - i_modulus);
            end else begin
                n_rem[i] = W'(shifted);
            end
            n_dvd[i] = {din[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < DIV_DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int i = 1; i < DIV_DEPTH; i++) begin
            r_side[i] <= r_side[i-1];
        end
        for (int i = 0; i < DIV_DEPTH; i++) begin
            r_rem[i] <= n_rem[i];
            r_dvd[i] <= n_dvd[i];
        end
    end

    assign o_valid = r_vld[DIV_DEPTH-1];
    assign o_rem   = r_rem[DIV_DEPTH-1];
    assign o_side  = r_side[DIV_DEPTH-1];

endmodule

[design/mma_checker.sv]
// Port-level checks for the Montgomery modular ALU, bound to the top level.
module mma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_result
);
    import mma_pkg::*;

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_valid)
        else $error("accepted item gave no result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without an accepted item, result %h", o_result);

endmodule

bind montgomery_modular_alu_core mma_checker u_mma_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
